/* rtl/core/byte_level_unicode_codec_top_defines.svh */
// ----------------------------------------------------------------------------
// Byte-level Unicode codec assertion macros
// Shared property wrappers for the codec's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BYTE_LEVEL_UNICODE_CODEC_TOP_DEFINES_SVH
`define BYTE_LEVEL_UNICODE_CODEC_TOP_DEFINES_SVH

// Check a property on the codec clock, idle while reset is held.
`define BLC_CHECK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition never holds.
`define BLC_NEVER(label, cond, msg) \
    `BLC_CHECK(label, !(cond), msg)

`endif

/* rtl/core/blcodec_pkg.sv */
// ----------------------------------------------------------------------------
// Byte-level Unicode codec package
// Types, constants and mapping functions shared by the codec modules.
// ----------------------------------------------------------------------------
package blcodec_pkg;

    localparam int QUEUE_DEPTH = 4;

    // Register indexes on the configuration port
    localparam logic [0:0] REG_DIRECTION    = 1'b0;
    localparam logic [0:0] REG_PASS_UNKNOWN = 1'b1;

    // Alphabet ranges that map to themselves
    localparam logic [7:0] PRINT_LO  = 8'd33;
    localparam logic [7:0] PRINT_HI  = 8'd126;
    localparam logic [7:0] LATIN_LO  = 8'd161;
    localparam logic [7:0] LATIN_HI  = 8'd172;
    localparam logic [7:0] LATIN2_LO = 8'd174;

    // Shifted code points: 256 + rank, 68 ranks
    localparam logic [7:0] SHIFT_COUNT = 8'd68;
    localparam logic [6:0] RANK_GAP1   = 7'd33;   // first rank of 127..160
    localparam logic [6:0] RANK_SHY    = 7'd67;   // rank of the soft hyphen
    localparam logic [7:0] GAP1_OFFSET = 8'd94;   // 127 - 33
    localparam logic [7:0] SHY_BYTE    = 8'd173;
    localparam logic [8:0] GAP0_BASE   = 9'd256;
    localparam logic [8:0] GAP1_BASE   = 9'd162;  // 256 + 33 - 127
    localparam logic [8:0] SHY_CODE    = 9'd323;
    localparam logic [7:0] GAP1_HI     = 8'd160;

    // UTF-8 framing
    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_CONT  = 8'h80;
    localparam logic [7:0] UTF_MASK6 = 8'h3F;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n;
    } t_res;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } t_job;

    typedef struct packed {
        logic       direction;
        logic [1:0] held_count;
        logic [2:0] exp_len;
    } t_front_status;

    function automatic logic [2:0] lead_length(input logic [7:0] c);
        logic [2:0] len;
        if (!c[7]) begin
            len = 3'd1;
        end else if (c[7:5] == 3'b110) begin
            len = 3'd2;
        end else if (c[7:4] == 4'b1110) begin
            len = 3'd3;
        end else if (c[7:3] == 5'b11110) begin
            len = 3'd4;
        end else begin
            len = 3'd1;
        end
        return len;
    endfunction

    function automatic logic self_mapped(input logic [7:0] v);
        return (v >= PRINT_LO && v <= PRINT_HI) || (v >= LATIN_LO && v <= LATIN_HI) ||
               (v >= LATIN2_LO);
    endfunction

    function automatic logic [7:0] rank_to_byte(input logic [6:0] r);
        logic [7:0] b;
        if (r < RANK_GAP1) begin
            b = {1'b0, r};
        end else if (r < RANK_SHY) begin
            b = {1'b0, r} + GAP1_OFFSET;
        end else begin
            b = SHY_BYTE;
        end
        return b;
    endfunction

    function automatic t_res no_result();
        t_res r;
        r.bytes = '0;
        r.n     = 3'd0;
        return r;
    endfunction

    // Map one gathered sequence of len bytes back to a raw byte, or pass / drop it
    function automatic t_res decode_seq(input logic [7:0] s0, input logic [7:0] s1,
                                        input logic [7:0] s2, input logic [7:0] s3,
                                        input logic [2:0] len, input logic pass);
        t_res        r;
        logic [10:0] cp;
        logic        two_ok;
        r.bytes = {s3, s2, s1, s0};
        r.n     = 3'd0;
        cp      = {s0[4:0], s1[5:0]};
        two_ok  = (len == 3'd2) && (s1[7:6] == 2'b10);
        if (len == 3'd1 && s0 >= PRINT_LO && s0 <= PRINT_HI) begin
            r.n = 3'd1;
        end else if (two_ok && cp[10:8] == 3'b000 && cp[7] && self_mapped(cp[7:0])) begin
            r.bytes[0] = cp[7:0];
            r.n        = 3'd1;
        end else if (two_ok && cp[10:8] == 3'b001 && cp[7:0] < SHIFT_COUNT) begin
            r.bytes[0] = rank_to_byte(cp[6:0]);
            r.n        = 3'd1;
        end else if (pass) begin
            r.n = len;
        end
        return r;
    endfunction

    function automatic t_res encode_byte(input logic [7:0] b);
        t_res       r;
        logic [8:0] cp;
        if (self_mapped(b)) begin
            cp = {1'b0, b};
        end else if (b < PRINT_LO) begin
            cp = GAP0_BASE | {1'b0, b};
        end else if (b <= GAP1_HI) begin
            cp = {1'b0, b} + GAP1_BASE;
        end else begin
            cp = SHY_CODE;
        end
        r.bytes = '0;
        if (cp[8:7] == 2'b00) begin
            r.bytes[0] = cp[7:0];
            r.n        = 3'd1;
        end else begin
            r.bytes[0] = UTF_LEAD2 | {5'd0, cp[8:6]};
            r.bytes[1] = UTF_CONT | ({2'b00, cp[5:0]} & UTF_MASK6);
            r.n        = 3'd2;
        end
        return r;
    endfunction

    // Concatenate two short result lists (total at most four)
    function automatic t_res append_res(input t_res a, input t_res b);
        t_res r;
        for (int i = 0; i < 4; i++) begin
            if (i < int'(a.n)) begin
                r.bytes[i] = a.bytes[i];
            end else begin
                r.bytes[i] = b.bytes[2'(i - int'(a.n))];
            end
        end
        r.n = a.n + b.n;
        return r;
    endfunction

endpackage

/* rtl/core/blcodec_front.sv */
// ----------------------------------------------------------------------------
// Byte-level Unicode codec front end
// Holds config and open-sequence state, turns producing requests into jobs.
// ----------------------------------------------------------------------------
module blcodec_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [0:0]                 i_cfg_data,
    input  logic                       i_accept,
    input  logic [7:0]                 i_in_byte,
    input  logic                       i_end_of_text,
    output logic                       o_push,
    output blcodec_pkg::t_job          o_job,
    output blcodec_pkg::t_front_status o_status
);

    logic       r_direction;
    logic       r_pass_unknown;
    logic [7:0] r_held [3];
    logic [1:0] r_held_count;
    logic [2:0] r_exp_len;

    logic [7:0]        seq [4];
    logic [2:0]        cnt;
    logic [2:0]        len_raw;
    logic [2:0]        len;
    logic              complete;
    logic [2:0]        l1;
    logic [2:0]        l2;
    blcodec_pkg::t_res seq_res;
    blcodec_pkg::t_res one1;
    blcodec_pkg::t_res one2;
    blcodec_pkg::t_res pair;
    blcodec_pkg::t_res scan_res;
    blcodec_pkg::t_res res;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            seq[i] = (int'(r_held_count) == i) ? i_in_byte : r_held[i];
        end
        seq[3] = i_in_byte;
        cnt     = {1'b0, r_held_count} + 3'd1;
        len_raw = (r_held_count != 2'd0) ? r_exp_len : blcodec_pkg::lead_length(seq[0]);
        len     = (len_raw == 3'd0 || len_raw > 3'd4) ? blcodec_pkg::lead_length(seq[0])
                                                      : len_raw;
        complete = (cnt >= len);
        seq_res  = blcodec_pkg::decode_seq(seq[0], seq[1], seq[2], seq[3], len,
                                           r_pass_unknown);

        // Rescan after dropping the lead byte of an unfinished sequence
        l1   = blcodec_pkg::lead_length(seq[1]);
        l2   = blcodec_pkg::lead_length(seq[2]);
        one1 = blcodec_pkg::decode_seq(seq[1], 8'd0, 8'd0, 8'd0, 3'd1, r_pass_unknown);
        one2 = blcodec_pkg::decode_seq(seq[2], 8'd0, 8'd0, 8'd0, 3'd1, r_pass_unknown);
        pair = blcodec_pkg::decode_seq(seq[1], seq[2], 8'd0, 8'd0, 3'd2, r_pass_unknown);
        scan_res = blcodec_pkg::no_result();
        if (cnt == 3'd2) begin
            if (l1 == 3'd1) begin
                scan_res = one1;
            end
        end else if (cnt == 3'd3) begin
            if (l1 == 3'd1) begin
                scan_res = blcodec_pkg::append_res(one1, (l2 == 3'd1) ? one2
                                                          : blcodec_pkg::no_result());
            end else if (l1 == 3'd2) begin
                scan_res = pair;
            end else if (l2 == 3'd1) begin
                scan_res = one2;
            end
        end

        if (r_direction) begin
            res = blcodec_pkg::encode_byte(i_in_byte);
        end else if (complete) begin
            res = seq_res;
        end else if (i_end_of_text) begin
            res = scan_res;
        end else begin
            res = blcodec_pkg::no_result();
        end
    end

    assign o_push         = i_accept && (res.n != 3'd0);
    assign o_job.bytes    = res.bytes;
    assign o_job.last_idx = 2'(res.n - 3'd1);

    assign o_status.direction  = r_direction;
    assign o_status.held_count = r_held_count;
    assign o_status.exp_len    = r_exp_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction    <= 1'b0;
            r_pass_unknown <= 1'b1;
            r_held_count   <= 2'd0;
            r_exp_len      <= 3'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    blcodec_pkg::REG_DIRECTION:    r_direction    <= i_cfg_data[0];
                    blcodec_pkg::REG_PASS_UNKNOWN: r_pass_unknown <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_accept && !r_direction) begin
                if (complete || i_end_of_text) begin
                    r_held_count <= 2'd0;
                    r_exp_len    <= 3'd0;
                end else begin
                    r_held_count <= cnt[1:0];
                    r_exp_len    <= len;
                end
            end
        end
    end

    // Held bytes only matter below the fill count
    always_ff @(posedge i_clk) begin
        if (i_accept && !r_direction && !complete && !i_end_of_text) begin
            for (int i = 0; i < 3; i++) begin
                r_held[i] <= seq[i];
            end
        end
    end

endmodule

/* rtl/core/blcodec_fifo.sv */
// ----------------------------------------------------------------------------
// Byte-level Unicode codec job queue
// Small FIFO of jobs between the front end and the output serializer.
// ----------------------------------------------------------------------------
module blcodec_fifo #(
    parameter int Depth = blcodec_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  blcodec_pkg::t_job i_job,
    input  logic              i_pop,
    output blcodec_pkg::t_job o_head,
    output logic              o_full,
    output logic              o_empty
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);

    blcodec_pkg::t_job r_mem [Depth];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [CW-1:0]     r_count;

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_count == CW'(Depth));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/core/blcodec_back.sv */
// ----------------------------------------------------------------------------
// Byte-level Unicode codec back end
// Walks the head job one byte a cycle, while popped, into the result register.
// ----------------------------------------------------------------------------
module blcodec_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  blcodec_pkg::t_job i_head,
    input  logic              i_head_valid,
    input  logic              i_pop,
    output logic              o_head_pop,
    output logic              o_empty,
    output logic [7:0]        o_out_byte,
    output logic              o_last_of_run
);

    logic       r_valid;
    logic [1:0] r_idx;
    logic [7:0] r_byte;
    logic       r_last;

    logic load;
    logic at_last;

    assign load       = i_head_valid && (!r_valid || i_pop);
    assign at_last    = (r_idx == i_head.last_idx);
    assign o_head_pop = load && at_last;

    assign o_empty       = !r_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= at_last;
        end
    end

endmodule

/* rtl/core/byte_level_unicode_codec_top.sv */
// ----------------------------------------------------------------------------
// Byte-level Unicode codec
// Converts raw bytes to and from the byte-level Unicode alphabet in UTF-8.
// ----------------------------------------------------------------------------
// Both sides look like a queue: push a request (one text byte plus an
// end-of-text flag) while full is low, and pop result bytes while empty is
// low. Register 0 (direction) selects decode (0) or encode (1); register 1
// (pass_unknown) chooses whether unmatched decode sequences are passed through
// or dropped; write them only while the block is idle. A request is taken
// every cycle as long as the job queue between the front end and the output
// serializer has room; each request yields zero to four result bytes, and
// the serializer hands out exactly one result byte per cycle while results
// are popped, so the sustained input rate is one request per cycle when
// requests average one result and falls as requests yield more. The first
// result of a request passes through the job queue and then the registered
// result slot before it can be popped. The last result byte of each request
// carries last_of_run. Requests that yield no result bytes use no queue slot.
`include "byte_level_unicode_codec_top_defines.svh"

module byte_level_unicode_codec_top #(
    parameter int QueueDepth = blcodec_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [0:0] i_cfg_data,
    // request side
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    // result side
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    logic                       in_accept;
    logic                       front_push;
    blcodec_pkg::t_job          front_job;
    blcodec_pkg::t_front_status front_status;
    blcodec_pkg::t_job          head_job;
    logic                       fifo_full;
    logic                       fifo_empty;
    logic                       head_pop;

    // Take a request whenever the job queue has a free slot
    assign full      = fifo_full;
    assign in_accept = push && !fifo_full;

    blcodec_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (in_accept),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_push        (front_push),
        .o_job         (front_job),
        .o_status      (front_status)
    );

    // Jobs wait here so each side can stall on its own
    blcodec_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .i_pop   (head_pop),
        .o_head  (head_job),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    // Serialize the head job into the registered result slot
    blcodec_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_job),
        .i_head_valid  (!fifo_empty),
        .i_pop         (pop),
        .o_head_pop    (head_pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    // Encoding always yields one or two bytes
    `BLC_CHECK(a_enc_job_size, (in_accept && front_status.direction) |-> (front_push && (front_job.last_idx <= 2'd1)), "encode request did not produce one or two bytes")

    // An open decode sequence is always shorter than its expected length
    `BLC_NEVER(a_open_seq_len, (front_status.held_count != 2'd0) && ((front_status.exp_len <= 3'(front_status.held_count)) || (front_status.exp_len > 3'd4)), "open decode sequence has a bad expected length")

    // With everything drained a producing request passes the job queue and then the result slot
    `BLC_CHECK(a_idle_latency, (in_accept && front_push && fifo_empty && empty) |=> ##1 !empty, "result did not appear two cycles after an idle request")

endmodule
